>>> design/mme_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared types, codes and fixed widths for the engine's modules.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int VAL_W     = 32;  // signed Q16.16
  localparam int FRAC_W    = 16;
  localparam int IDX_W     = 6;
  localparam int CMD_W     = 2;
  localparam int ROW_W     = 3;
  localparam int CFG_W     = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INNER = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        elem_index;
    logic signed [VAL_W-1:0] elem_value;
  } request_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] product_value;
    logic [ROW_W-1:0]        out_row;
    logic [ROW_W-1:0]        out_col;
    logic                    last;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_a;        // write left store
    logic wr_b;        // write right store
    logic rd_en;       // one multiply-accumulate step issued
    logic first;       // first step of a dot product
    logic final_step;  // last step of a dot product
    logic emit;        // move finished result into output register
    logic last_elem;   // emitted element is the final one
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic res_valid;   // rounded dot product waiting
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

endpackage

>>> design/mme_stream_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface mme_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/mme_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mme_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine controller
// Configuration registers, load range checks and the row/column/inner
// sequencer that walks both stores for a compute command.
// ----------------------------------------------------------------------------
module mme_ctrl #(
  parameter int MAX_DIM = 8,
  localparam int CNT_W  = $clog2(MAX_DIM + 1),
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [mme_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [mme_pkg::CFG_W-1:0]     write_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [mme_pkg::CMD_W-1:0]     req_cmd,
  input  logic [mme_pkg::IDX_W-1:0]     req_index,
  input  mme_pkg::dp_stat_t             stat,
  output mme_pkg::dp_ctrl_t             ctrl,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic [ADDR_W-1:0]             rd_addr_a,
  output logic [ADDR_W-1:0]             rd_addr_b,
  output logic [mme_pkg::ROW_W-1:0]     out_row,
  output logic [mme_pkg::ROW_W-1:0]     out_col
);

  localparam int LIM_W = 2 * CNT_W;
  localparam int CMP_W = (LIM_W > mme_pkg::IDX_W) ? LIM_W : mme_pkg::IDX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                state;
  logic [mme_pkg::CFG_W-1:0] rows_reg;
  logic [mme_pkg::CFG_W-1:0] cols_reg;
  logic [mme_pkg::CFG_W-1:0] inner_reg;
  logic [CNT_W-1:0]          rows;
  logic [CNT_W-1:0]          cols;
  logic [CNT_W-1:0]          inner;
  logic [CNT_W-1:0]          r;
  logic [CNT_W-1:0]          c;
  logic [CNT_W-1:0]          t;
  logic [ADDR_W-1:0]         a_addr;
  logic [ADDR_W-1:0]         b_addr;
  logic [ADDR_W-1:0]         col_base;
  logic [LIM_W-1:0]          lim_a;
  logic [LIM_W-1:0]          lim_b;
  logic                      accept;
  logic                      row_end;
  logic                      col_end;

  function automatic logic [CNT_W-1:0] eff_dim(input logic [mme_pkg::CFG_W-1:0] v);
    logic [CNT_W-1:0] d;
    if (v == '0) begin
      d = CNT_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      d = CNT_W'(MAX_DIM);
    end else begin
      d = CNT_W'(v);
    end
    return d;
  endfunction

  assign rows  = eff_dim(rows_reg);
  assign cols  = eff_dim(cols_reg);
  assign inner = eff_dim(inner_reg);
  assign lim_a = LIM_W'(rows) * LIM_W'(inner);
  assign lim_b = LIM_W'(inner) * LIM_W'(cols);

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign row_end   = (r == rows - CNT_W'(1));
  assign col_end   = (c == cols - CNT_W'(1));

  always_comb begin
    ctrl.wr_a       = accept && (req_cmd == mme_pkg::CMD_LOAD_A)
                      && (CMP_W'(req_index) < CMP_W'(lim_a));
    ctrl.wr_b       = accept && (req_cmd == mme_pkg::CMD_LOAD_B)
                      && (CMP_W'(req_index) < CMP_W'(lim_b));
    ctrl.rd_en      = (state == S_ISSUE);
    ctrl.first      = (t == '0);
    ctrl.final_step = (t == inner - CNT_W'(1));
    ctrl.emit       = (state == S_DRAIN) && stat.res_valid && stat.out_free;
    ctrl.last_elem  = row_end && col_end;
  end

  assign wr_addr   = ADDR_W'(req_index);
  assign rd_addr_a = a_addr;
  assign rd_addr_b = b_addr;
  assign out_row   = mme_pkg::ROW_W'(r);
  assign out_col   = mme_pkg::ROW_W'(c);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rows_reg  <= mme_pkg::DIM_RESET;
      cols_reg  <= mme_pkg::DIM_RESET;
      inner_reg <= mme_pkg::DIM_RESET;
      r         <= '0;
      c         <= '0;
      t         <= '0;
      a_addr    <= '0;
      b_addr    <= '0;
      col_base  <= '0;
    end else begin
      if (write_enable) begin
        unique case (reg_index)
          mme_pkg::REG_ROWS:  rows_reg  <= write_data;
          mme_pkg::REG_COLS:  cols_reg  <= write_data;
          mme_pkg::REG_INNER: inner_reg <= write_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (req_cmd == mme_pkg::CMD_COMPUTE)) begin
            state    <= S_ISSUE;
            r        <= '0;
            c        <= '0;
            t        <= '0;
            a_addr   <= '0;
            b_addr   <= '0;
            col_base <= '0;
          end
        end
        S_ISSUE: begin
          if (ctrl.final_step) begin
            state <= S_DRAIN;
            t     <= '0;
          end else begin
            t      <= t + CNT_W'(1);
            a_addr <= a_addr + ADDR_W'(rows);
            b_addr <= b_addr + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          // hold until the dot product lands in the output register
          if (ctrl.emit) begin
            if (row_end) begin
              r      <= '0;
              a_addr <= '0;
              if (col_end) begin
                state <= S_IDLE;
              end else begin
                state    <= S_ISSUE;
                c        <= c + CNT_W'(1);
                col_base <= col_base + ADDR_W'(inner);
                b_addr   <= col_base + ADDR_W'(inner);
              end
            end else begin
              state  <= S_ISSUE;
              r      <= r + CNT_W'(1);
              a_addr <= ADDR_W'(r) + ADDR_W'(1);
              b_addr <= col_base;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/mme_datapath.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine datapath
// Operand stores, multiplier, wide accumulator, rounding with saturation
// and the output register.
// ----------------------------------------------------------------------------
module mme_datapath #(
  parameter int MAX_DIM = 8,
  localparam int CNT_W  = $clog2(MAX_DIM + 1),
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mme_pkg::dp_ctrl_t             ctrl,
  output mme_pkg::dp_stat_t             stat,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [mme_pkg::VAL_W-1:0]     wr_data,
  input  logic [ADDR_W-1:0]             rd_addr_a,
  input  logic [ADDR_W-1:0]             rd_addr_b,
  input  logic [mme_pkg::ROW_W-1:0]     out_row,
  input  logic [mme_pkg::ROW_W-1:0]     out_col,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mme_pkg::result_t              result_payload
);

  localparam int VAL_W  = mme_pkg::VAL_W;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int SH_W   = ACC_W - mme_pkg::FRAC_W;

  logic [VAL_W-1:0]         a_data;
  logic [VAL_W-1:0]         b_data;
  logic                     rd_v;
  logic                     rd_first;
  logic                     rd_final;
  logic signed [PROD_W-1:0] prod;
  logic                     p_v;
  logic                     p_first;
  logic                     p_final;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_done;
  logic signed [ACC_W-1:0]  rnd;
  logic [SH_W-1:0]          shifted;
  logic [SH_W-VAL_W:0]      top;
  logic [VAL_W-1:0]         sat;
  logic                     res_valid;
  logic [VAL_W-1:0]         res_value;

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) left_store (
    .clk   (clk),
    .we    (ctrl.wr_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_a),
    .rdata (a_data)
  );

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) right_store (
    .clk   (clk),
    .we    (ctrl.wr_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_b),
    .rdata (b_data)
  );

  // round to nearest, ties up, then clamp to 32 bits
  assign rnd     = acc + (ACC_W'(1) <<< (mme_pkg::FRAC_W - 1));
  assign shifted = rnd[ACC_W-1:mme_pkg::FRAC_W];
  assign top     = shifted[SH_W-1:VAL_W-1];

  always_comb begin
    if ((&top) || !(|top)) begin
      sat = shifted[VAL_W-1:0];
    end else if (top[SH_W-VAL_W]) begin
      sat = mme_pkg::VAL_MIN;
    end else begin
      sat = mme_pkg::VAL_MAX;
    end
  end

  assign stat.res_valid = res_valid;
  assign stat.out_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v         <= 1'b0;
      p_v          <= 1'b0;
      acc_done     <= 1'b0;
      res_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_v     <= ctrl.rd_en;
      p_v      <= rd_v;
      acc_done <= p_v && p_final;
      if (acc_done) begin
        res_valid <= 1'b1;
      end else if (ctrl.emit) begin
        res_valid <= 1'b0;
      end
      if (ctrl.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= ctrl.first;
    rd_final <= ctrl.final_step;
    p_first  <= rd_first;
    p_final  <= rd_final;
    prod     <= $signed(a_data) * $signed(b_data);
    if (p_v) begin
      acc <= (p_first ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
    if (acc_done) begin
      res_value <= sat;
    end
    if (ctrl.emit) begin
      result_payload.product_value <= res_value;
      result_payload.out_row       <= out_row;
      result_payload.out_col       <= out_col;
      result_payload.last          <= ctrl.last_elem;
    end
  end

endmodule

>>> design/matrix_multiply_engine_core.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine
// C = A * B on signed Q16.16 matrices held column-major in two stores.
// ----------------------------------------------------------------------------
// Channel   Dir   Handshake       Payload
// request   in    valid/ready     cmd, elem_index, elem_value
// result    out   valid/ready     product_value, out_row, out_col, last
// config    in    write_enable    reg_index, write_data
//
// Loads stream back to back.
// In a compute, each element walks the inner dimension one
// multiply-accumulate per cycle through the store read ports, then
// drains through multiply, accumulate and rounding registers.
// request.ready is low during a compute.
// Reset is synchronous; dimensions return to 8, store contents are kept.
// A stalled result holds the sequencer before the next element is issued.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core #(
  parameter int MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [mme_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [mme_pkg::CFG_W-1:0]     write_data,
  mme_stream_if.sink                    request,
  mme_stream_if.source                  result
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  mme_pkg::dp_ctrl_t            ctrl;
  mme_pkg::dp_stat_t            stat;
  mme_pkg::request_t            req;
  mme_pkg::result_t             res;
  logic [ADDR_W-1:0]            wr_addr;
  logic [ADDR_W-1:0]            rd_addr_a;
  logic [ADDR_W-1:0]            rd_addr_b;
  logic [mme_pkg::ROW_W-1:0]    out_row;
  logic [mme_pkg::ROW_W-1:0]    out_col;
  logic                         req_ready;
  logic                         res_valid;

  assign req            = request.payload;
  assign request.ready  = req_ready;
  assign result.valid   = res_valid;
  assign result.payload = res;

  mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .req_valid    (request.valid),
    .req_ready    (req_ready),
    .req_cmd      (req.cmd),
    .req_index    (req.elem_index),
    .stat         (stat),
    .ctrl         (ctrl),
    .wr_addr      (wr_addr),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .out_row      (out_row),
    .out_col      (out_col)
  );

  mme_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .wr_addr        (wr_addr),
    .wr_data        (req.elem_value),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .out_row        (out_row),
    .out_col        (out_col),
    .result_valid   (res_valid),
    .result_ready   (result.ready),
    .result_payload (res)
  );

endmodule
